// ===== src/mrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mrc_pkg: shared types and constants of the MQTT reply checker
// Packet type codes, field masks, the per-packet parse state and the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

package mrc_pkg;

  // Awaited reply kinds, as sampled from the action field on the first byte
  localparam logic KIND_CONNACK = 1'b0;
  localparam logic KIND_PING    = 1'b1;

  // Fixed-header type nibbles
  localparam logic [3:0] TYPE_CONNACK  = 4'h2;
  localparam logic [3:0] TYPE_PINGRESP = 4'hd;

  // Remaining-length field coding
  localparam logic [7:0] LEN_CONT_MASK = 8'h80;
  localparam logic [7:0] LEN_DATA_MASK = 8'h7f;
  localparam int unsigned LenGroupBits = 7;
  localparam int unsigned LenValueBits = 28;

  // Session-present flag in the acknowledge flags byte
  localparam logic [7:0] SESSION_MASK = 8'h01;

  // Expected remaining lengths
  localparam logic [LenValueBits-1:0] CONNACK_LENGTH  = LenValueBits'(2);
  localparam logic [LenValueBits-1:0] PINGRESP_LENGTH = LenValueBits'(0);

  // Parse state carried from one byte to the next
  typedef struct packed {
    logic                    awaited_kind;
    logic [3:0]              packet_type;
    logic [LenValueBits-1:0] length_value;
    logic [2:0]              length_bytes;
    logic                    length_done;
    logic                    failed;
    logic [7:0]              code_byte;
  } mrc_state_t;

  // Verdict for one packet
  typedef struct packed {
    logic       status;
    logic [7:0] return_code;
  } mrc_verdict_t;

endpackage : mrc_pkg

`default_nettype wire

// ===== src/mrc_step.sv =====
// ----------------------------------------------------------------------------
// mrc_step: per-byte next-state and verdict logic
// Folds one packet byte into the parse state and forms the verdict that
// applies if this byte closes the buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_step #(
  parameter int unsigned MAX_LENGTH_BYTES = 4,
  parameter int unsigned MAX_BUFFER_BYTES = 255,
  parameter int unsigned PosW             = $clog2(MAX_BUFFER_BYTES + 1)
) (
  input  mrc_pkg::mrc_state_t   state_i,
  input  logic [PosW-1:0]       pos_i,
  input  logic                  action_i,
  input  logic [7:0]            byte_value_i,
  input  logic                  last_byte_i,
  output mrc_pkg::mrc_state_t   state_o,
  output logic [PosW-1:0]       pos_o,
  output mrc_pkg::mrc_verdict_t verdict_o
);
  import mrc_pkg::*;

  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_BUFFER_BYTES);
  localparam logic [2:0]      MaxLb  = 3'(MAX_LENGTH_BYTES);

  mrc_state_t              st;
  logic [2:0]              lb_inc;
  logic [5:0]              shift_amt;
  logic [LenValueBits-1:0] group;
  logic [PosW:0]           pos_ext;
  logic [PosW:0]           lb_ext;
  logic                    ok;

  // Weight of the current length group: seven bits per byte
  assign shift_amt = 6'(state_i.length_bytes) * 6'(LenGroupBits);
  assign group     = LenValueBits'(byte_value_i & LEN_DATA_MASK) << shift_amt;
  assign lb_inc    = state_i.length_bytes + 3'd1;
  assign pos_ext   = {1'b0, pos_i};
  assign lb_ext    = (PosW + 1)'(state_i.length_bytes);

  // Field walk for this byte
  always_comb begin
    st = state_i;
    if (pos_i == '0) begin
      // Fixed header: sample kind and type, restart the packet
      st.awaited_kind = action_i;
      st.packet_type  = byte_value_i[7:4];
      st.length_value = '0;
      st.length_bytes = '0;
      st.length_done  = 1'b0;
      st.failed       = 1'b0;
      st.code_byte    = '0;
    end else if (pos_i >= MaxPos) begin
      st.failed = 1'b1;
    end else if (!state_i.length_done) begin
      if (!state_i.failed) begin
        st.length_value = state_i.length_value + group;
        st.length_bytes = lb_inc;
        if ((byte_value_i & LEN_CONT_MASK) == '0) begin
          st.length_done = 1'b1;
        end else if (lb_inc >= MaxLb) begin
          st.failed = 1'b1;
        end
      end
    end else if (state_i.awaited_kind == KIND_CONNACK) begin
      // Variable header of the acknowledge: flags, then return code
      if (pos_ext == lb_ext + (PosW + 1)'(1)) begin
        if ((byte_value_i & SESSION_MASK) != '0) begin
          st.failed = 1'b1;
        end
      end else if (pos_ext == lb_ext + (PosW + 1)'(2)) begin
        st.code_byte = byte_value_i;
      end
    end
  end

  // Position: saturating count, back to zero after the last byte
  always_comb begin
    if (last_byte_i) begin
      pos_o = '0;
    end else if (pos_i < MaxPos) begin
      pos_o = pos_i + PosW'(1);
    end else begin
      pos_o = pos_i;
    end
  end

  // Verdict on the updated state
  always_comb begin
    ok = !st.failed && st.length_done;
    if (st.awaited_kind == KIND_CONNACK) begin
      ok = ok && (st.packet_type == TYPE_CONNACK) && (st.length_value == CONNACK_LENGTH)
           && (pos_ext + (PosW + 1)'(1) >= (PosW + 1)'(st.length_bytes) + (PosW + 1)'(3));
    end else begin
      ok = ok && (st.packet_type == TYPE_PINGRESP) && (st.length_value == PINGRESP_LENGTH);
    end
    verdict_o.status      = !ok;
    verdict_o.return_code = (ok && st.awaited_kind == KIND_CONNACK) ? st.code_byte : 8'h00;
  end

  assign state_o = st;

endmodule : mrc_step

`default_nettype wire

// ===== src/mqtt_response_checker_top.sv =====
// ----------------------------------------------------------------------------
// mqtt_response_checker_top: checker for received MQTT reply packets
// Parses the fixed header, remaining length and acknowledge fields byte by
// byte and reports one verdict per packet.
// ----------------------------------------------------------------------------
// Feed a packet one byte per item, marking the final byte with last_byte_i
// and giving the awaited reply (0 connect acknowledge, 1 ping response) on
// the first byte. Each byte is folded into the parse state in the cycle it
// is accepted, and the final byte's verdict is loaded into an output
// register in that same cycle, so it appears in the cycle after
// acceptance. Bytes stream at one per cycle; the input stalls only while a
// verdict sits in the output register and the consumer is not taking it.
// status_o is 0 for a well formed packet of the awaited kind, and
// return_code_o then carries the connect return code (0 for ping response).
`default_nettype none

module mqtt_response_checker_top #(
  parameter int unsigned MAX_LENGTH_BYTES = 4,
  parameter int unsigned MAX_BUFFER_BYTES = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] byte_value_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       status_o,
  output logic [7:0] return_code_o
);
  import mrc_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_BUFFER_BYTES + 1);
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_BUFFER_BYTES);

  mrc_state_t      state_q, state_d;
  logic [PosW-1:0] pos_q, pos_d;
  mrc_verdict_t    verdict;
  logic            out_valid_q;
  logic            status_q;
  logic [7:0]      code_q;
  logic            in_fire;

  // Output register frees up when empty or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  mrc_step #(
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES),
    .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES),
    .PosW             (PosW)
  ) u_step (
    .state_i      (state_q),
    .pos_i        (pos_q),
    .action_i     (action_i),
    .byte_value_i (byte_value_i),
    .last_byte_i  (last_byte_i),
    .state_o      (state_d),
    .pos_o        (pos_d),
    .verdict_o    (verdict)
  );

  // Parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      pos_q   <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

  // Result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && last_byte_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_fire && last_byte_i) begin
      status_q <= verdict.status;
      code_q   <= verdict.return_code;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign return_code_o = code_q;

`ifndef ASSERT_OFF
  // A failing verdict never carries a return code
  a_code_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> return_code_o == 8'h00)
    else $error("return code nonzero on failing verdict");

  // Only a final byte produces a result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !last_byte_i |=> !out_valid_o)
    else $error("result without final byte");

  // A final byte yields a result and rewinds the position
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last_byte_i |=> out_valid_o && pos_q == '0)
    else $error("final byte did not yield a result");

  // Position stays within the buffer limit
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= MaxPos)
    else $error("byte position past buffer limit");
`endif

endmodule : mqtt_response_checker_top

`default_nettype wire
